[design/lgps_pkg.sv]
// ----------------------------------------------------------------------------
// lgps_pkg
// Shared types and constants for the light-gun position smoother.
// ----------------------------------------------------------------------------
package lgps_pkg;

  localparam int RAW_W     = 8;   // raw_x / raw_y width
  localparam int MAPX_W    = 9;   // remapped horizontal position
  localparam int CUR_X_W   = 11;  // cursor_x width
  localparam int CUR_Y_W   = 10;  // cursor_y width
  localparam int OFS_W     = 8;   // offset register width
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // Reciprocal table for the mean: q = (sum * RECIP[n]) >> RECIP_SHIFT.
  // Exact for sums below 2^12 and counts up to 8.
  localparam int RECIP_SHIFT = 15;
  localparam int RECIP_W     = 16;
  localparam logic [RECIP_W-1:0] RECIP [16] = '{
    16'd0,     16'd32768, 16'd16384, 16'd10923,
    16'd8192,  16'd6554,  16'd5462,  16'd4682,
    16'd4096,  16'd0,     16'd0,     16'd0,
    16'd0,     16'd0,     16'd0,     16'd0
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AVG_ENABLE = 2'd0,
    REG_X_OFFSET   = 2'd1,
    REG_Y_OFFSET   = 2'd2
  } reg_idx_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic update;   // remap and update the ring and running sums
    logic scale;    // form the means
    logic commit;   // load the cursor register
  } dp_cmd_t;

endpackage

[design/lgps_dp.sv]
// ----------------------------------------------------------------------------
// lgps_dp
// Datapath: config registers, x remap, sample ring with running sums,
// reciprocal-multiply mean and the held cursor register.
// ----------------------------------------------------------------------------
module lgps_dp
  import lgps_pkg::*;
#(
  parameter int RING_DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]       cfg_data_i,
  input  logic [RAW_W-1:0]           raw_x_i,
  input  logic                       x_valid_i,
  input  logic [RAW_W-1:0]           raw_y_i,
  output logic signed [CUR_X_W-1:0]  cursor_x_o,
  output logic signed [CUR_Y_W-1:0]  cursor_y_o
);

  localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUMX_W = MAPX_W + $clog2(RING_DEPTH);
  localparam int SUMY_W = RAW_W + $clog2(RING_DEPTH);
  localparam int PRODX_W = SUMX_W + RECIP_W;
  localparam int PRODY_W = SUMY_W + RECIP_W;

  localparam logic [RAW_W-1:0] X_LO_START  = 8'd60;
  localparam logic [RAW_W-1:0] X_GAP_START = 8'd183;
  localparam logic [RAW_W-1:0] X_HI_START  = 8'd228;

  function automatic logic [MAPX_W-1:0] remap_x(input logic [RAW_W-1:0] x);
    logic [MAPX_W-1:0] xe;
    logic [MAPX_W-1:0] r;
    xe = {1'b0, x};
    if (x >= X_LO_START && x < X_GAP_START) begin
      r = (xe - 9'd60) << 1;
    end else if (x >= X_HI_START) begin
      r = ((xe - 9'd228) << 1) + 9'd246;
    end else if (x < X_LO_START) begin
      r = (xe << 1) + 9'd302;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // Config registers
  logic                    avg_en_q;
  logic signed [OFS_W-1:0] x_ofs_q;
  logic signed [OFS_W-1:0] y_ofs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_en_q <= 1'b0;
      x_ofs_q  <= -8'sd20;
      y_ofs_q  <= 8'sd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AVG_ENABLE: avg_en_q <= cfg_data_i[0];
        REG_X_OFFSET:   x_ofs_q  <= $signed(cfg_data_i);
        REG_Y_OFFSET:   y_ofs_q  <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Request registers
  logic [RAW_W-1:0] raw_x_q, raw_y_q;
  logic             x_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      raw_x_q   <= raw_x_i;
      x_valid_q <= x_valid_i;
      raw_y_q   <= raw_y_i;
    end
  end

  logic [MAPX_W-1:0] mx;
  assign mx = remap_x(raw_x_q);

  // Ring storage
  logic [MAPX_W-1:0] slot_x_q [RING_DEPTH];
  logic [RAW_W-1:0]  slot_y_q [RING_DEPTH];
  logic [RING_DEPTH-1:0] slot_valid_q;
  logic [PTR_W-1:0]  ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SUMX_W-1:0] sum_x_q;
  logic [SUMY_W-1:0] sum_y_q;

  logic              old_valid;
  logic [SUMX_W-1:0] old_x;
  logic [SUMY_W-1:0] old_y;
  logic [PTR_W-1:0]  ptr_next;

  assign old_valid = slot_valid_q[ptr_q];
  assign old_x     = old_valid ? SUMX_W'(slot_x_q[ptr_q]) : '0;
  assign old_y     = old_valid ? SUMY_W'(slot_y_q[ptr_q]) : '0;
  assign ptr_next  = (ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && avg_en_q && x_valid_q) begin
      slot_x_q[ptr_q] <= mx;
      slot_y_q[ptr_q] <= raw_y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      ptr_q        <= '0;
      cnt_q        <= '0;
      sum_x_q      <= '0;
      sum_y_q      <= '0;
    end else if (cmd_i.update && avg_en_q) begin
      if (x_valid_q) begin
        // swap the overwritten entry out of the running sums
        slot_valid_q[ptr_q] <= 1'b1;
        ptr_q   <= ptr_next;
        cnt_q   <= old_valid ? cnt_q : cnt_q + 1'b1;
        sum_x_q <= sum_x_q - old_x + SUMX_W'(mx);
        sum_y_q <= sum_y_q - old_y + SUMY_W'(raw_y_q);
      end else begin
        // lost aim: drop the ring
        slot_valid_q <= '0;
        ptr_q        <= '0;
        cnt_q        <= '0;
        sum_x_q      <= '0;
        sum_y_q      <= '0;
      end
    end
  end

  // Mean by reciprocal multiply
  logic [RECIP_W-1:0]  recip;
  logic [PRODX_W-1:0]  prod_x;
  logic [PRODY_W-1:0]  prod_y;
  logic [MAPX_W-1:0]   mean_x_q;
  logic [RAW_W-1:0]    mean_y_q;

  assign recip  = RECIP[4'(cnt_q)];
  assign prod_x = PRODX_W'(sum_x_q) * PRODX_W'(recip);
  assign prod_y = PRODY_W'(sum_y_q) * PRODY_W'(recip);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      mean_x_q <= prod_x[RECIP_SHIFT +: MAPX_W];
      mean_y_q <= prod_y[RECIP_SHIFT +: RAW_W];
    end
  end

  // Held cursor
  logic signed [CUR_X_W-1:0] held_x_q, held_x_d;
  logic signed [CUR_Y_W-1:0] held_y_q, held_y_d;
  logic [MAPX_W-1:0]         sel_x;
  logic [RAW_W-1:0]          sel_y;

  assign sel_x = avg_en_q ? mean_x_q : mx;
  assign sel_y = avg_en_q ? mean_y_q : raw_y_q;

  always_comb begin
    held_x_d = held_x_q;
    held_y_d = held_y_q;
    if (x_valid_q) begin
      held_x_d = $signed(CUR_X_W'(sel_x)) + CUR_X_W'(x_ofs_q);
      held_y_d = $signed(CUR_Y_W'(sel_y)) + CUR_Y_W'(y_ofs_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q <= 11'sd152;
      held_y_q <= 10'sd104;
    end else if (cmd_i.commit) begin
      held_x_q <= held_x_d;
      held_y_q <= held_y_d;
    end
  end

  assign cursor_x_o = held_x_q;
  assign cursor_y_o = held_y_q;

  a_cnt_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CNT_W'($countones(slot_valid_q)))
    else $error("ring count does not match valid slots");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_W'(RING_DEPTH - 1))
    else $error("ring pointer out of range");

  a_scale_has_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scale && avg_en_q && x_valid_q) |-> (cnt_q != '0))
    else $error("mean formed over an empty ring");

endmodule

[design/lgps_ctrl.sv]
// ----------------------------------------------------------------------------
// lgps_ctrl
// Controller: sequences capture, ring update, scaling and commit, and owns
// the request handshakes on both channels.
// ----------------------------------------------------------------------------
module lgps_ctrl
  import lgps_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCALE,
    ST_COMMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE:   if (in_valid_i) state_q <= ST_UPDATE;
        ST_UPDATE: state_q <= ST_SCALE;
        ST_SCALE:  state_q <= ST_COMMIT;
        ST_COMMIT: begin
          // hold until the output register can take the new cursor
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.update  = (state_q == ST_UPDATE);
  assign cmd_o.scale   = (state_q == ST_SCALE);
  assign cmd_o.commit  = (state_q == ST_COMMIT) && out_free;

  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("commit did not raise output valid");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !(out_valid_q && out_stall_i))
    else $error("cursor overwritten while stalled");

endmodule

[design/light_gun_position_smoother.sv]
// ----------------------------------------------------------------------------
// light_gun_position_smoother
// Light-gun cursor smoother: x remap, optional ring-average, offsets.
// ----------------------------------------------------------------------------
// Sequence: the controller runs capture, ring update, reciprocal multiply
// and commit for each request and stalls the input until it is back in
// idle; commit waits while the output is stalled. The output register
// lets the next request in while the last cursor is still stalled.
// Reset: ring empty, pointer 0, cursor 152/104, averaging off, offsets -20/0.
module light_gun_position_smoother
  import lgps_pkg::*;
#(
  parameter int RING_DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]       cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [RAW_W-1:0]           raw_x_i,
  input  logic                       x_valid_i,
  input  logic [RAW_W-1:0]           raw_y_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [CUR_X_W-1:0]  cursor_x_o,
  output logic signed [CUR_Y_W-1:0]  cursor_y_o
);

  dp_cmd_t cmd;

  lgps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lgps_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .raw_x_i    (raw_x_i),
    .x_valid_i  (x_valid_i),
    .raw_y_i    (raw_y_i),
    .cursor_x_o (cursor_x_o),
    .cursor_y_o (cursor_y_o)
  );

endmodule
